>>> src/rmbh_pkg.sv
// Package with the constants, codes and control types of the ring mix byte hash.
`timescale 1ns / 1ps

package rmbh_pkg;

  localparam int unsigned RING_DEPTH_DEF = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam int unsigned MIX_ROUND_CAP = 256;
  localparam int unsigned RND_W = $clog2(MIX_ROUND_CAP + 1);

  localparam logic [WORD_W-1:0] MIX_ADD_A = 32'd14921776;
  localparam logic [WORD_W-1:0] MIX_MUL_A = 32'd17761492;
  localparam logic [WORD_W-1:0] MIX_XOR_A = 32'h05827066;
  localparam logic [WORD_W-1:0] MIX_ADD_B = 32'h0002c357;
  localparam logic [WORD_W-1:0] MIX_MUL_B = 32'd10661688;
  localparam logic [WORD_W-1:0] MIX_TEST_MASK = 32'h80000002;
  localparam logic [WORD_W-1:0] MIX_TEST_VAL = 32'h00000002;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_ABSORB = 1'b1;

  typedef struct packed {
    logic clear;
    logic load;
    logic rnd_a;
    logic rnd_b;
    logic write;
    logic emit;
  } rmbh_cmd_t;

  typedef struct packed {
    logic mix_again;
  } rmbh_stat_t;

endpackage

>>> src/rmbh_in_if.sv
// Input channel interface carrying the operation and the data byte.
`timescale 1ns / 1ps

interface rmbh_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

>>> src/rmbh_out_if.sv
// Output channel interface carrying the digest word.
`timescale 1ns / 1ps

interface rmbh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest;

  modport source (output valid, output digest, input ready);
  modport sink (input valid, input digest, output ready);
endinterface

>>> src/rmbh_datapath.sv
// Datapath with the rotating word ring, the mix register and the digest register.
`timescale 1ns / 1ps

module rmbh_datapath import rmbh_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmbh_cmd_t           cmd_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  output rmbh_stat_t          stat_o,
  output logic [WORD_W-1:0]   digest_o
);

  // The ring rotates so that the read word always sits at index 0 and the
  // write word at index 1.
  logic [WORD_W-1:0] ring_q [RING_DEPTH];
  logic [WORD_W-1:0] ring_d [RING_DEPTH];
  logic [WORD_W-1:0] x_q, x_d;
  logic [WORD_W-1:0] digest_q;
  logic [WORD_W-1:0] prod_a, prod_b, sum_a, sum_b;

  assign prod_a = x_q * (MIX_MUL_A + x_q);
  assign sum_a  = x_q + MIX_ADD_A + prod_a;
  assign prod_b = x_q * (MIX_MUL_B ^ x_q);
  assign sum_b  = x_q + MIX_ADD_B + prod_b;

  always_comb begin
    x_d = x_q;
    if (cmd_i.load) begin
      x_d = ring_q[0] + {{(WORD_W-BYTE_W){1'b0}}, data_byte_i};
    end else if (cmd_i.rnd_a) begin
      x_d = sum_a ^ MIX_XOR_A;
    end else if (cmd_i.rnd_b) begin
      x_d = sum_b ^ (sum_b >> 16);
    end
  end

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_d[i] = ring_q[i];
    end
    if (cmd_i.clear) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_d[i] = '0;
      end
    end else if (cmd_i.write) begin
      for (int i = 0; i < RING_DEPTH - 1; i++) begin
        ring_d[i] = ring_q[i+1];
      end
      ring_d[RING_DEPTH-1] = ring_q[0];
      ring_d[0] = ring_q[1] + x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < RING_DEPTH; i++) begin
        ring_q[i] <= ring_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (cmd_i.emit) begin
      digest_q <= ring_d[0] ^ ring_d[1];
    end
  end

  assign stat_o.mix_again = ((x_q & MIX_TEST_MASK) == MIX_TEST_VAL);
  assign digest_o = digest_q;

endmodule

>>> src/rmbh_ctrl.sv
// Controller that sequences the mix rounds and owns the channel handshakes.
`timescale 1ns / 1ps

module rmbh_ctrl import rmbh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  rmbh_stat_t stat_i,
  output rmbh_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RND_A = 2'd1;
  localparam logic [1:0] ST_RND_B = 2'd2;
  localparam logic [1:0] ST_TEST  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;
  logic             in_acc;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op_i == OP_CLEAR) begin
            cmd_o.clear = 1'b1;
            cmd_o.emit  = 1'b1;
            out_valid_d = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            rnd_d      = '0;
            state_d    = ST_RND_A;
          end
        end
      end
      ST_RND_A: begin
        cmd_o.rnd_a = 1'b1;
        state_d     = ST_RND_B;
      end
      ST_RND_B: begin
        cmd_o.rnd_b = 1'b1;
        rnd_d       = rnd_q + 1'b1;
        state_d     = ST_TEST;
      end
      ST_TEST: begin
        if (stat_i.mix_again && (rnd_q < RND_W'(MIX_ROUND_CAP))) begin
          state_d = ST_RND_A;
        end else if (slot_free) begin
          cmd_o.write = 1'b1;
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/ring_mix_byte_hash.sv
// Top level of the ring mix byte hash: controller, datapath and assertions.
//
// Usage: items arrive on in_i (op, data_byte) and each yields one digest word
// on out_o, in order. A word moves when valid and ready are both high.
// op clear zeroes the ring; op absorb mixes data_byte into the ring.
// A clear item shows its digest in the cycle after acceptance. An absorb item
// loads its byte and then runs R mix rounds before its digest is written,
// where R is 1 for most bytes, about 1.3 on average and at most 256; each
// round runs the first and then the second 32-bit multiply step, then the
// repeat test.
// The block takes one item at a time; the next item is taken once the
// controller is back in idle and the previous digest has left or is leaving
// the output register.
// Reset clears the ring, the controller state and the output valid flag at once.
// When the receiver stalls, the digest waits in the output register and no
// further item is accepted until that digest has been taken.
`timescale 1ns / 1ps

module ring_mix_byte_hash import rmbh_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmbh_in_if.sink    in_i,
  rmbh_out_if.source out_o
);

  rmbh_cmd_t  cmd;
  rmbh_stat_t stat;

  rmbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.op),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rmbh_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (in_i.data_byte),
    .stat_o      (stat),
    .digest_o    (out_o.digest)
  );

`ifndef SYNTHESIS
  a_clear_gives_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.op == OP_CLEAR)) |=>
      (out_o.valid && (out_o.digest == '0)))
    else $error("clear item did not produce a zero digest");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.ready && out_o.valid) |-> out_o.ready)
    else $error("input taken while a stalled digest occupies the output");

  a_absorb_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.op == OP_ABSORB)) |=> !in_i.ready)
    else $error("input ready while an absorb item is still mixing");
`endif

endmodule
